// ===== src/swa_pkg.sv =====
// ----------------------------------------------------------------------------
// swa_pkg
// shared types and constants of the selective-repeat sender window
// ----------------------------------------------------------------------------
`default_nettype none

package swa_pkg;

  localparam int WINDOW   = 4;
  localparam int SEQ_W    = 16;
  localparam int AGE_W    = 16;
  localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic [SEQ_W-1:0] TIMEOUT_RESET = SEQ_W'(20000);

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ACK  = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_PACKET_TOTAL  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_TICKS = REG_IDX_W'(1);

  // one window slot, slot k belongs to base + k
  typedef struct packed {
    logic             acked;
    logic [AGE_W-1:0] age;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic mark;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/swa_ifs.sv =====
// ----------------------------------------------------------------------------
// swa channel interfaces
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
`default_nettype none

interface swa_in_if;
  import swa_pkg::*;
  logic             valid;
  logic             ready;
  logic             op;
  logic [SEQ_W-1:0] ack_seq;

  modport source (output valid, output op, output ack_seq, input ready);
  modport sink (input valid, input op, input ack_seq, output ready);
endinterface

interface swa_out_if;
  import swa_pkg::*;
  logic             valid;
  logic             ready;
  logic             send_valid;
  logic [SEQ_W-1:0] send_seq;
  logic             is_resend;
  logic             final_packet;
  logic [SEQ_W-1:0] window_base;
  logic             all_done;
  logic             last;

  modport source (
    output valid, output send_valid, output send_seq, output is_resend,
    output final_packet, output window_base, output all_done, output last,
    input ready
  );
  modport sink (
    input valid, input send_valid, input send_seq, input is_resend,
    input final_packet, input window_base, input all_done, input last,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/sliding_window_arq_sender.sv =====
// ----------------------------------------------------------------------------
// sliding_window_arq_sender: a tick runs one ring rotation over all slots, then a flush
// an ack slides the window (one slide per cycle), then a flush; scan and flush wait on output stalls
// one item at a time; rst clears window state, timeout_ticks resets to 20000
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_arq_sender import swa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  swa_in_if.sink             item,
  swa_out_if.source          result
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SLIDE = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t state;

  logic [SEQ_W-1:0]  packet_total;
  logic [SEQ_W-1:0]  timeout_ticks;
  logic [SEQ_W-1:0]  base_seq;
  logic [SEQ_W-1:0]  next_seq;
  logic [CNT_W-1:0]  outs;
  logic [CNT_W-1:0]  scan_outs;
  logic [SLOT_W-1:0] cnt;

  logic             hold_valid;
  logic [SEQ_W-1:0] hold_seq;
  logic             hold_resend;
  logic             hold_final;

  slot_t     slots [WINDOW];
  cell_ctl_t ctl [WINDOW];
  slot_t     tail_in;

  // register file
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_total  <= '0;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      if (reg_idx == REG_PACKET_TOTAL) begin
        packet_total <= pwdata[SEQ_W-1:0];
      end else if (reg_idx == REG_TIMEOUT_TICKS) begin
        timeout_ticks <= pwdata[SEQ_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_PACKET_TOTAL:  prdata = PDATA_W'(packet_total);
      REG_TIMEOUT_TICKS: prdata = PDATA_W'(timeout_ticks);
      default:           prdata = '0;
    endcase
  end

  // handshake and step conditions
  logic             accept;
  logic             out_free;
  logic             scan_step;
  logic             slide_step;
  logic             flush_step;
  logic [SEQ_W-1:0] ack_off;
  logic             ack_hit;

  assign item.ready = (state == ST_IDLE);
  assign accept     = item.valid && item.ready;
  assign out_free   = !result.valid || result.ready;
  assign scan_step  = (state == ST_SCAN) && out_free;
  assign slide_step = (state == ST_SLIDE) && (outs != '0) && slots[0].acked;
  assign flush_step = (state == ST_FLUSH) && out_free;
  assign ack_off    = item.ack_seq - base_seq;
  assign ack_hit    = ack_off < SEQ_W'(outs);

  // head cell processing during the scan
  slot_t            head_next;
  logic             gen;
  logic             gen_resend;
  logic             gen_final;
  logic             issue;
  logic [SEQ_W-1:0] gen_seq;
  logic [SEQ_W-1:0] seq_at;
  logic             in_old;

  assign seq_at = base_seq + SEQ_W'(cnt);
  assign in_old = CNT_W'(cnt) < scan_outs;

  always_comb begin
    head_next  = slots[0];
    gen        = 1'b0;
    gen_resend = 1'b0;
    gen_seq    = '0;
    issue      = 1'b0;
    if (in_old) begin
      if (!slots[0].acked && (seq_at < packet_total)) begin
        if (slots[0].age >= timeout_ticks) begin
          gen            = 1'b1;
          gen_resend     = 1'b1;
          gen_seq        = seq_at;
          head_next.age  = '0;
        end else begin
          head_next.age = slots[0].age + AGE_W'(1);
        end
      end
    end else if (next_seq < packet_total) begin
      gen       = 1'b1;
      gen_seq   = next_seq;
      head_next = '0;
      issue     = 1'b1;
    end
  end

  assign gen_final = (packet_total != '0) && (gen_seq == packet_total - SEQ_W'(1));

  // chain of slot cells, shifts toward slot 0
  assign tail_in = scan_step ? head_next : slot_t'('0);

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    assign ctl[k].shift = scan_step || slide_step;
    assign ctl[k].mark  = accept && (item.op == OP_ACK) && ack_hit &&
                          (ack_off[SLOT_W-1:0] == SLOT_W'(k));
    if (k == WINDOW - 1) begin : g_tail
      swa_cell u_cell (.clk(clk), .rst(rst), .ctl(ctl[k]), .nbr(tail_in), .q(slots[k]));
    end else begin : g_body
      swa_cell u_cell (.clk(clk), .rst(rst), .ctl(ctl[k]), .nbr(slots[k+1]), .q(slots[k]));
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      base_seq  <= '0;
      next_seq  <= '0;
      outs      <= '0;
      scan_outs <= '0;
      cnt       <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cnt       <= '0;
            scan_outs <= outs;
            state     <= (item.op == OP_ACK) ? ST_SLIDE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_step) begin
            cnt <= cnt + SLOT_W'(1);
            if (issue) begin
              next_seq <= next_seq + SEQ_W'(1);
              outs     <= outs + CNT_W'(1);
            end
            if (cnt == SLOT_W'(WINDOW - 1)) begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_SLIDE: begin
          if (slide_step) begin
            base_seq <= base_seq + SEQ_W'(1);
            outs     <= outs - CNT_W'(1);
          end else begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (flush_step) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // one result is held back so the final beat can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (scan_step && gen) begin
      hold_valid <= 1'b1;
    end else if (flush_step) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_step && gen) begin
      hold_seq    <= gen_seq;
      hold_resend <= gen_resend;
      hold_final  <= gen_final;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if ((scan_step && gen && hold_valid) || flush_step) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((scan_step && gen && hold_valid) || flush_step) begin
      result.send_valid   <= hold_valid;
      result.send_seq     <= hold_valid ? hold_seq : '0;
      result.is_resend    <= hold_valid && hold_resend;
      result.final_packet <= hold_valid && hold_final;
      result.window_base  <= base_seq;
      result.all_done     <= base_seq >= packet_total;
      result.last         <= flush_step;
    end
  end

`ifndef SYNTH
  a_outs_track: assert property (@(posedge clk) disable iff (rst)
    SEQ_W'(outs) == (next_seq - base_seq))
    else $error("outstanding count out of step with sequence numbers");

  a_outs_bound: assert property (@(posedge clk) disable iff (rst)
    outs <= CNT_W'(WINDOW))
    else $error("window overfilled");

  a_ack_path: assert property (@(posedge clk) disable iff (rst)
    accept && (item.op == OP_ACK) |=> (state == ST_SLIDE) && !hold_valid)
    else $error("ack did not enter slide with empty hold");

  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    flush_step |=> result.valid && result.last)
    else $error("flush did not present a last beat");
`endif

endmodule

`default_nettype wire

// ===== src/swa_cell.sv =====
// ----------------------------------------------------------------------------
// swa_cell
// one window slot: takes its right neighbor on a shift, sets acked on a mark
// ----------------------------------------------------------------------------
`default_nettype none

module swa_cell import swa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  slot_t     nbr,
  output slot_t     q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (ctl.shift) begin
      q <= nbr;
    end else if (ctl.mark) begin
      q.acked <= 1'b1;
    end
  end

endmodule

`default_nettype wire
